/* rtl/core/isbc_pkg.sv */
// ----------------------------------------------------------------------------
// isbc_pkg
// Types, constants and layer functions for the involutive S-box block cipher.
// ----------------------------------------------------------------------------
package isbc_pkg;

    localparam int unsigned NUM_RKEYS = 9;
    localparam int unsigned NUM_ROUNDS = 8;

    typedef logic [63:0] t_block;
    typedef logic [7:0]  t_byte;

    localparam t_block LAYER_C0 = 64'hb7e151628aed2a6a;
    localparam t_block LAYER_C1 = 64'hbf7158809cf4f3c7;

    localparam logic [7:0] MASK_LO = 8'h55;
    localparam logic [7:0] MASK_HI = 8'haa;

    localparam t_block SCHED_C [NUM_RKEYS] = '{
        64'h290d61409ceb9e8f, 64'h1f855f585b013986, 64'h972ed7d635ae1716,
        64'h21b6694ea5728708, 64'h3c18e6e7faadb889, 64'hb700f76f73841163,
        64'h3f967f6ebf149dac, 64'ha40e7ef6204a6230, 64'h03c54b5a46a34465
    };

    localparam t_byte SBOX [256] = '{
    8'h29,8'h0d,8'h61,8'h40,8'h9c,8'heb,8'h9e,8'h8f,8'h1f,8'h85,8'h5f,8'h58,8'h5b,8'h01,8'h39,8'h86,
    8'h97,8'h2e,8'hd7,8'hd6,8'h35,8'hae,8'h17,8'h16,8'h21,8'hb6,8'h69,8'h4e,8'ha5,8'h72,8'h87,8'h08,
    8'h3c,8'h18,8'he6,8'he7,8'hfa,8'had,8'hb8,8'h89,8'hb7,8'h00,8'hf7,8'h6f,8'h73,8'h84,8'h11,8'h63,
    8'h3f,8'h96,8'h7f,8'h6e,8'hbf,8'h14,8'h9d,8'hac,8'ha4,8'h0e,8'h7e,8'hf6,8'h20,8'h4a,8'h62,8'h30,
    8'h03,8'hc5,8'h4b,8'h5a,8'h46,8'ha3,8'h44,8'h65,8'h7d,8'h4d,8'h3d,8'h42,8'h79,8'h49,8'h1b,8'h5c,
    8'hf5,8'h6c,8'hb5,8'h94,8'h54,8'hff,8'h56,8'h57,8'h0b,8'hf4,8'h43,8'h0c,8'h4f,8'h70,8'h6d,8'h0a,
    8'he4,8'h02,8'h3e,8'h2f,8'ha2,8'h47,8'he0,8'hc1,8'hd5,8'h1a,8'h95,8'ha7,8'h51,8'h5e,8'h33,8'h2b,
    8'h5d,8'hd4,8'h1d,8'h2c,8'hee,8'h75,8'hec,8'hdd,8'h7c,8'h4c,8'ha6,8'hb4,8'h78,8'h48,8'h3a,8'h32,
    8'h98,8'haf,8'hc0,8'he1,8'h2d,8'h09,8'h0f,8'h1e,8'hb9,8'h27,8'h8a,8'he9,8'hbd,8'he3,8'h9f,8'h07,
    8'hb1,8'hea,8'h92,8'h93,8'h53,8'h6a,8'h31,8'h10,8'h80,8'hf2,8'hd8,8'h9b,8'h04,8'h36,8'h06,8'h8e,
    8'hbe,8'ha9,8'h64,8'h45,8'h38,8'h1c,8'h7a,8'h6b,8'hf3,8'ha1,8'hf0,8'hcd,8'h37,8'h25,8'h15,8'h81,
    8'hfb,8'h90,8'he8,8'hd9,8'h7b,8'h52,8'h19,8'h28,8'h26,8'h88,8'hfc,8'hd1,8'he2,8'h8c,8'ha0,8'h34,
    8'h82,8'h67,8'hda,8'hcb,8'hc7,8'h41,8'he5,8'hc4,8'hc8,8'hef,8'hdb,8'hc3,8'hcc,8'hab,8'hce,8'hed,
    8'hd0,8'hbb,8'hd3,8'hd2,8'h71,8'h68,8'h13,8'h12,8'h9a,8'hb3,8'hc2,8'hca,8'hde,8'h77,8'hdc,8'hdf,
    8'h66,8'h83,8'hbc,8'h8d,8'h60,8'hc6,8'h22,8'h23,8'hb2,8'h8b,8'h91,8'h05,8'h76,8'hcf,8'h74,8'hc9,
    8'haa,8'hf1,8'h99,8'ha8,8'h59,8'h50,8'h3b,8'h2a,8'hfe,8'hf9,8'h24,8'hb0,8'hba,8'hfd,8'hf8,8'h55
    };

    // Control travelling alongside the data through the round chain
    typedef struct packed {
        logic valid;
        logic kind;
    } t_cell_ctl;

    function automatic t_byte rot8(input t_byte v);
        return {v[6:0], v[7]};
    endfunction

    // Byte k counted from the most significant end
    function automatic t_byte byte_at(input t_block v, input int k);
        return v[63-8*k -: 8];
    endfunction

    // Key schedule function: nibble-swapped S-box then 8x8 bit transpose
    function automatic t_block sched_f(input t_block c, input t_block x);
        t_block v;
        t_block s;
        t_block r;
        t_byte  b;
        v = x ^ c;
        for (int i = 0; i < 8; i++) begin
            b = byte_at(v, i);
            s[63-8*i -: 8] = SBOX[{b[3:0], b[7:4]}];
        end
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++)
                r[8*j+i] = s[63-8*i-j];
        return r;
    endfunction

    // One forward mix and shuffle layer
    function automatic t_block fwd_layer(input t_block x);
        t_block y;
        t_byte  a;
        t_byte  b;
        for (int i = 0; i < 4; i++) begin
            a = byte_at(x, 2*i);
            b = byte_at(x, 2*i+1);
            y[63-8*i -: 8] = SBOX[((rot8(a) & MASK_LO) ^ a) ^ b];
            y[31-8*i -: 8] = SBOX[rot8(a) ^ b];
        end
        return y;
    endfunction

    // One inverse layer
    function automatic t_block inv_layer(input t_block x);
        t_block y;
        t_byte  pa;
        t_byte  pb;
        t_byte  z;
        t_byte  yl;
        for (int i = 0; i < 4; i++) begin
            pa = SBOX[byte_at(x, i)];
            pb = SBOX[byte_at(x, 4+i)];
            z  = pa ^ pb;
            yl = (rot8(z) & MASK_HI) ^ z;
            y[63-16*i -: 8] = yl;
            y[55-16*i -: 8] = rot8(yl) ^ pb;
        end
        return y;
    endfunction

endpackage

/* rtl/core/isbc_round_cell.sv */
// ----------------------------------------------------------------------------
// isbc_round_cell
// One round of the chain: three layers plus round key, forward or inverse.
// Registered at its output; advances whenever the chain is not stalled.
// ----------------------------------------------------------------------------
module isbc_round_cell
    import isbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  t_cell_ctl i_ctl,
    input  t_block    i_data,
    input  t_block    i_key_enc,
    input  t_block    i_key_dec,
    output t_cell_ctl o_ctl,
    output t_block    o_data
);

    t_cell_ctl r_ctl;
    t_block    r_data;
    t_block    n_data;

    // Round datapath
    always_comb begin
        if (!i_ctl.kind)
            n_data = fwd_layer(fwd_layer(fwd_layer(i_data) ^ LAYER_C0) ^ LAYER_C1)
                     ^ i_key_enc;
        else
            n_data = inv_layer(inv_layer(inv_layer(i_data) ^ LAYER_C1) ^ LAYER_C0)
                     ^ i_key_dec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_data = r_data;

endmodule

/* rtl/core/isbc_key_sched.sv */
// ----------------------------------------------------------------------------
// isbc_key_sched
// Round key schedule: one key derived per cycle after reset or a key write.
// ----------------------------------------------------------------------------
module isbc_key_sched
    import isbc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_block i_key,
    output logic   o_busy,
    output t_block o_rkey [NUM_RKEYS]
);

    t_block     r_rk [NUM_RKEYS];
    t_block     r_key;
    logic [3:0] r_idx;
    logic       r_busy;
    t_block     n_prev2;
    t_block     n_new;

    // Next key from the last two
    always_comb begin
        n_prev2 = (r_idx == 4'd1) ? r_key : r_rk[r_idx - 4'd2];
        if (r_idx == 4'd0)
            n_new = sched_f(SCHED_C[0], r_key);
        else
            n_new = n_prev2 ^ sched_f(SCHED_C[r_idx], r_rk[r_idx - 4'd1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_key  <= '0;
        end else if (i_wr) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_key  <= i_key;
        end else if (r_busy) begin
            r_idx  <= r_idx + 4'd1;
            r_busy <= (r_idx != 4'(NUM_RKEYS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !i_wr) begin
            r_rk[r_idx] <= n_new;
        end
    end

    assign o_busy = r_busy;
    assign o_rkey = r_rk;

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx < 4'(NUM_RKEYS)) else $error("key index overrun");
    a_wr_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |=> (r_busy && r_idx == 4'd0)) else $error("write did not restart");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_wr && r_idx == 4'(NUM_RKEYS - 1)) |=> !r_busy)
        else $error("schedule did not finish");
`endif

endmodule

/* rtl/core/involutive_sbox_block_cipher.sv */
// ----------------------------------------------------------------------------
// involutive_sbox_block_cipher
// 64-bit block cipher, one block per cycle when not stalled, through a chain of eight rounds.
// ----------------------------------------------------------------------------
// Each round cell holds one item and hands it on every cycle unless the chain
// holds, so one block is accepted per cycle when not stalled. The whitening
// register is loaded on acceptance and the eight round cells follow, the last
// of them being the output register. The whole chain holds while a result
// waits at the output and i_stall is high. A key write derives the nine round
// keys one per cycle, so input is refused while the schedule is busy after
// reset or a key write.
module involutive_sbox_block_cipher
    import isbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [63:0] i_block_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_block_out
);

    logic      ks_busy;
    t_block    rkey [NUM_RKEYS];
    logic      adv;
    t_cell_ctl r_ctl0;
    t_block    r_data0;
    t_cell_ctl ctl  [NUM_ROUNDS+1];
    t_block    data [NUM_ROUNDS+1];

    // Chain advances unless the result at the end is held
    assign adv         = !(ctl[NUM_ROUNDS].valid && i_stall);
    assign o_stall     = !adv || ks_busy;
    assign o_cfg_ready = 1'b1;

    isbc_key_sched u_ks (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_key   (i_cfg_data),
        .o_busy  (ks_busy),
        .o_rkey  (rkey)
    );

    // Whitening stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (adv) begin
            r_ctl0 <= '{valid: i_valid && !ks_busy, kind: i_kind};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_data0 <= i_block_in ^ (i_kind ? rkey[NUM_RKEYS-1] : rkey[0]);
        end
    end

    assign ctl[0]  = r_ctl0;
    assign data[0] = r_data0;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        isbc_round_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (adv),
            .i_ctl     (ctl[g]),
            .i_data    (data[g]),
            .i_key_enc (rkey[g+1]),
            .i_key_dec (rkey[NUM_ROUNDS-1-g]),
            .o_ctl     (ctl[g+1]),
            .o_data    (data[g+1])
        );
    end

    assign o_valid     = ctl[NUM_ROUNDS].valid;
    assign o_block_out = data[NUM_ROUNDS];

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_block_out)))
        else $error("held result changed");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ks_busy |-> o_stall) else $error("item taken during schedule");
    a_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_ctl0.valid) |=> ctl[1].valid) else $error("item lost in chain");
`endif

endmodule
